// ===== hdl/lmsp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmsp_pkg: shared types and constants for the linear move step profile unit
// Status and phase codes, config register indexes, reset values, FSM states.
// ----------------------------------------------------------------------------
package lmsp_pkg;

    localparam int MIN_STEP_DEF  = 655;
    localparam int FRAC_BITS_DEF = 16;
    localparam logic signed [31:0] HOME_Z_DEF = 32'sd0;

    localparam int POS_W  = 32;
    localparam int DIST_W = 34;
    localparam int STEP_W = 31;

    localparam logic signed [31:0] BOX_LO_RST = -32'sd6553600;
    localparam logic signed [31:0] BOX_HI_RST = 32'sd6553600;
    localparam logic [30:0] ZONE_RST = 31'd655360;
    localparam logic [30:0] MAX_STEP_RST = 31'd65536;

    typedef enum logic [2:0] {
        ST_STEP  = 3'd0,
        ST_START = 3'd1,
        ST_DONE  = 3'd2,
        ST_FAIL  = 3'd3,
        ST_IDLE  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ACCEL = 2'd1,
        PH_FULL  = 2'd2,
        PH_DECEL = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        CFG_X_LOWER    = 3'd0,
        CFG_X_UPPER    = 3'd1,
        CFG_Y_LOWER    = 3'd2,
        CFG_Y_UPPER    = 3'd3,
        CFG_Z_LOWER    = 3'd4,
        CFG_Z_UPPER    = 3'd5,
        CFG_ACCEL_ZONE = 3'd6,
        CFG_MAX_STEP   = 3'd7
    } cfg_idx_t;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_CLAMP = 13'b0000000000010,
        S_DMAG  = 13'b0000000000100,
        S_DSQ   = 13'b0000000001000,
        S_DSQRT = 13'b0000000010000,
        S_GDEC  = 13'b0000000100000,
        S_UDIV  = 13'b0000001000000,
        S_TPLAN = 13'b0000010000000,
        S_MMUL  = 13'b0000100000000,
        S_MDIV  = 13'b0001000000000,
        S_ADV   = 13'b0010000000000,
        S_TDEC  = 13'b0100000000000,
        S_EMIT  = 13'b1000000000000
    } state_t;

endpackage
`default_nettype wire

// ===== hdl/linear_move_step_profile_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// linear_move_step_profile_unit: trapezoidal-velocity linear move stepper
// Clamps goals to the workspace box, plans a unit direction, and on each
// tick emits the next Q format position along an accel/full/decel profile.
// ----------------------------------------------------------------------------
//  channel | handshake         | beat contents
//  --------+-------------------+---------------------------------------------
//  in      | in_valid/in_stall | kind, goal_x, goal_y, goal_z, actuator_ok
//  out     | out_valid/out_stall | pos_x, pos_y, pos_z, status
//  cfg     | cfg_we            | cfg_index, cfg_data
//
//  Goal beat: clamp, distance squares, bit-serial root, decide and emit, one
//  restoring divide per axis, one bit a cycle; a goal that finishes at once
//  skips the divides.
//  Tick beat: plan, map the step by a 62-bit restoring divide, advance, distance
//  squares and root, decide; full speed or a saturated step skips the divide.
//  One beat is in flight at a time; the next is taken once its result sits in
//  the output register, which holds while out_stall is high.
//  Reset clears the box and ramp registers to their defaults and parks at home.
// ----------------------------------------------------------------------------
module linear_move_step_profile_unit #(
    parameter int FRAC_BITS = lmsp_pkg::FRAC_BITS_DEF,
    parameter int MIN_STEP  = lmsp_pkg::MIN_STEP_DEF,
    parameter logic signed [31:0] HOME_Z = lmsp_pkg::HOME_Z_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               kind,
    input  wire logic signed [31:0] goal_x,
    input  wire logic signed [31:0] goal_y,
    input  wire logic signed [31:0] goal_z,
    input  wire logic               actuator_ok,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      pos_x,
    output logic signed [31:0]      pos_y,
    output logic signed [31:0]      pos_z,
    output logic [2:0]              status,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    localparam int UW = FRAC_BITS + 2;
    localparam int PW = UW + lmsp_pkg::STEP_W;
    localparam logic [5:0] UdivIters = 6'(32 + FRAC_BITS);
    localparam logic [5:0] MdivIters = 6'd62;
    localparam logic [33:0] MinStepD = 34'(MIN_STEP);
    localparam logic [30:0] MinStepS = 31'(MIN_STEP);
    localparam logic [PW:0] Half = {{PW{1'b0}}, 1'b1} << (FRAC_BITS - 1);

    lmsp_pkg::state_t  state_reg;
    lmsp_pkg::phase_t  phase_reg;
    lmsp_pkg::status_t res_status_reg;
    lmsp_pkg::status_t out_status_reg;

    logic              pending_reg;
    logic [1:0]        ax_reg;
    logic              dsel_reg;
    logic              ok_reg;
    logic signed [31:0] goal_reg [3];

    logic signed [31:0] lo_reg [3];
    logic signed [31:0] hi_reg [3];
    logic [30:0]        zone_reg;
    logic [30:0]        max_reg;

    logic signed [31:0] settled_reg [3];
    logic signed [31:0] moving_reg [3];
    logic signed [31:0] target_reg [3];
    logic signed [31:0] next_reg [3];
    logic signed [31:0] res_pos_reg [3];
    logic signed [31:0] out_pos_reg [3];
    logic               out_valid_reg;

    logic [UW-1:0]      umag_reg [3];
    logic               uneg_reg [3];
    logic [33:0]        total_reg;
    logic [33:0]        remain_reg;

    logic [31:0]        mag_reg [3];
    logic               dneg_reg [3];
    logic               big_reg;
    logic [63:0]        sq_n_reg;
    logic [63:0]        sq_r_reg;
    logic [63:0]        sq_b_reg;
    logic [33:0]        dist_reg;

    logic [63:0]        div_num_reg;
    logic [33:0]        div_rem_reg;
    logic [33:0]        div_den_reg;
    logic [63:0]        div_quo_reg;
    logic [5:0]         div_cnt_reg;

    logic [30:0]        x_reg;
    logic [30:0]        step_reg;

    // distance front end
    logic signed [31:0] da;
    logic signed [32:0] diff;
    logic [31:0]        dmag;
    logic [30:0]        sq_v;
    logic [61:0]        sq_p;
    logic [63:0]        sq_t;
    logic               sq_ge;
    logic [63:0]        sq_r_next;
    logic [33:0]        dist_next;

    // restoring divider, one quotient bit a cycle
    logic [34:0]        div_t;
    logic               div_ge;
    logic [34:0]        div_sub;
    logic [33:0]        div_rem_next;
    logic [63:0]        div_quo_next;

    // clamp
    logic signed [31:0] cl_lo;
    logic signed [31:0] cl_hi;
    logic signed [31:0] cl_a;
    logic signed [31:0] cl_g;

    // profile planning
    logic [34:0]        prev_z;
    logic               c_full;
    logic               prev_lt_zone;
    logic               c_dec;
    logic [33:0]        acc_x;
    lmsp_pkg::phase_t   np;
    logic               use_map;
    logic [33:0]        map_x;
    logic               map_max;
    logic [61:0]        prod;
    logic [31:0]        mapped;
    logic [30:0]        mapped_step;

    // advance
    logic [PW-1:0]      adv_p;
    logic [PW:0]        adv_pr;
    logic [35:0]        adv_d;
    logic [35:0]        adv_base;
    logic [35:0]        adv_sum;
    logic signed [31:0] adv_sat;

    logic               in_acc;

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = (state_reg != lmsp_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign pos_x     = out_pos_reg[0];
    assign pos_y     = out_pos_reg[1];
    assign pos_z     = out_pos_reg[2];
    assign status    = out_status_reg;

    assign da   = dsel_reg ? next_reg[ax_reg] : settled_reg[ax_reg];
    assign diff = {da[31], da} - {target_reg[ax_reg][31], target_reg[ax_reg]};
    assign dmag = diff[32] ? 32'(-diff) : diff[31:0];
    assign sq_v = big_reg ? mag_reg[ax_reg][31:1] : mag_reg[ax_reg][30:0];
    assign sq_p = sq_v * sq_v;

    assign sq_t      = sq_r_reg + sq_b_reg;
    assign sq_ge     = (sq_n_reg >= sq_t);
    assign sq_r_next = sq_ge ? ((sq_r_reg >> 1) + sq_b_reg) : (sq_r_reg >> 1);
    assign dist_next = big_reg ? {sq_r_next[32:0], 1'b0} : {1'b0, sq_r_next[32:0]};

    assign div_t        = {div_rem_reg, div_num_reg[63]};
    assign div_ge       = (div_t >= {1'b0, div_den_reg});
    assign div_sub      = div_t - {1'b0, div_den_reg};
    assign div_rem_next = div_ge ? div_sub[33:0] : div_t[33:0];
    assign div_quo_next = {div_quo_reg[62:0], div_ge};

    assign cl_lo = lo_reg[ax_reg];
    assign cl_hi = hi_reg[ax_reg];
    assign cl_a  = (goal_reg[ax_reg] < cl_lo) ? cl_lo : goal_reg[ax_reg];
    assign cl_g  = (cl_a > cl_hi) ? cl_hi : cl_a;

    assign prev_z       = {1'b0, remain_reg} + {4'b0, zone_reg};
    assign c_full       = ({1'b0, total_reg} > prev_z);
    assign prev_lt_zone = (remain_reg < {3'b0, zone_reg});
    assign c_dec        = prev_lt_zone && ({remain_reg, 1'b0} < {1'b0, total_reg});
    assign acc_x        = (total_reg > remain_reg) ? (total_reg - remain_reg) : 34'd0;

    always_comb
    begin
        np      = phase_reg;
        use_map = 1'b0;
        map_x   = 34'd0;
        if (phase_reg == lmsp_pkg::PH_ACCEL)
        begin
            if (c_full)
                np = lmsp_pkg::PH_FULL;
            else if (c_dec)
                np = lmsp_pkg::PH_DECEL;
            else
            begin
                use_map = 1'b1;
                map_x   = acc_x;
            end
        end
        if (np == lmsp_pkg::PH_FULL && prev_lt_zone)
            np = lmsp_pkg::PH_DECEL;
        if (np == lmsp_pkg::PH_DECEL)
        begin
            use_map = 1'b1;
            map_x   = remain_reg;
        end
    end

    assign map_max     = (map_x >= {3'b0, zone_reg}) || (max_reg <= MinStepS);
    assign prod        = x_reg * (max_reg - MinStepS);
    assign mapped      = {1'b0, MinStepS} + {1'b0, div_quo_next[30:0]};
    assign mapped_step = (mapped > {1'b0, max_reg}) ? max_reg : mapped[30:0];

    assign adv_p    = umag_reg[ax_reg] * step_reg;
    assign adv_pr   = {1'b0, adv_p} + Half;
    assign adv_d    = 36'(adv_pr >> FRAC_BITS);
    assign adv_base = {{4{moving_reg[ax_reg][31]}}, moving_reg[ax_reg]};
    assign adv_sum  = uneg_reg[ax_reg] ? (adv_base - adv_d) : (adv_base + adv_d);

    always_comb
    begin
        if (!adv_sum[35] && adv_sum[34:31] != 4'h0)
            adv_sat = 32'sh7FFF_FFFF;
        else if (adv_sum[35] && adv_sum[34:31] != 4'hF)
            adv_sat = 32'sh8000_0000;
        else
            adv_sat = adv_sum[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lmsp_pkg::S_IDLE;
            phase_reg      <= lmsp_pkg::PH_IDLE;
            res_status_reg <= lmsp_pkg::ST_IDLE;
            out_status_reg <= lmsp_pkg::ST_IDLE;
            pending_reg    <= 1'b0;
            ax_reg         <= 2'd0;
            dsel_reg       <= 1'b0;
            ok_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            zone_reg       <= lmsp_pkg::ZONE_RST;
            max_reg        <= lmsp_pkg::MAX_STEP_RST;
            total_reg      <= 34'd0;
            remain_reg     <= 34'd0;
            big_reg        <= 1'b0;
            sq_n_reg       <= 64'd0;
            sq_r_reg       <= 64'd0;
            sq_b_reg       <= 64'd0;
            dist_reg       <= 34'd0;
            div_num_reg    <= 64'd0;
            div_rem_reg    <= 34'd0;
            div_den_reg    <= 34'd0;
            div_quo_reg    <= 64'd0;
            div_cnt_reg    <= 6'd0;
            x_reg          <= 31'd0;
            step_reg       <= 31'd0;
            for (int i = 0; i < 3; i++)
            begin
                goal_reg[i]    <= 32'sd0;
                lo_reg[i]      <= lmsp_pkg::BOX_LO_RST;
                hi_reg[i]      <= lmsp_pkg::BOX_HI_RST;
                target_reg[i]  <= 32'sd0;
                next_reg[i]    <= 32'sd0;
                res_pos_reg[i] <= 32'sd0;
                out_pos_reg[i] <= 32'sd0;
                umag_reg[i]    <= '0;
                uneg_reg[i]    <= 1'b0;
                mag_reg[i]     <= 32'd0;
                dneg_reg[i]    <= 1'b0;
            end
            settled_reg[0] <= 32'sd0;
            settled_reg[1] <= 32'sd0;
            settled_reg[2] <= HOME_Z;
            moving_reg[0]  <= 32'sd0;
            moving_reg[1]  <= 32'sd0;
            moving_reg[2]  <= HOME_Z;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (lmsp_pkg::cfg_idx_t'(cfg_index))
                    lmsp_pkg::CFG_X_LOWER:    lo_reg[0] <= cfg_data;
                    lmsp_pkg::CFG_X_UPPER:    hi_reg[0] <= cfg_data;
                    lmsp_pkg::CFG_Y_LOWER:    lo_reg[1] <= cfg_data;
                    lmsp_pkg::CFG_Y_UPPER:    hi_reg[1] <= cfg_data;
                    lmsp_pkg::CFG_Z_LOWER:    lo_reg[2] <= cfg_data;
                    lmsp_pkg::CFG_Z_UPPER:    hi_reg[2] <= cfg_data;
                    lmsp_pkg::CFG_ACCEL_ZONE: zone_reg  <= cfg_data[30:0];
                    lmsp_pkg::CFG_MAX_STEP:   max_reg   <= cfg_data[30:0];
                    default: ;
                endcase
            end

            // drop the beat once taken, unless a new one loads this cycle
            if (out_valid_reg && !out_stall && state_reg != lmsp_pkg::S_EMIT)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                lmsp_pkg::S_IDLE:
                begin
                    if (in_acc)
                    begin
                        goal_reg[0] <= goal_x;
                        goal_reg[1] <= goal_y;
                        goal_reg[2] <= goal_z;
                        ok_reg      <= actuator_ok;
                        ax_reg      <= 2'd0;
                        if (!kind)
                        begin
                            pending_reg <= 1'b0;
                            state_reg   <= lmsp_pkg::S_CLAMP;
                        end
                        else
                            state_reg <= lmsp_pkg::S_TPLAN;
                    end
                end

                lmsp_pkg::S_CLAMP:
                begin
                    target_reg[ax_reg] <= cl_g;
                    if (ax_reg == 2'd2)
                    begin
                        ax_reg    <= 2'd0;
                        dsel_reg  <= 1'b0;
                        big_reg   <= 1'b0;
                        state_reg <= lmsp_pkg::S_DMAG;
                    end
                    else
                        ax_reg <= ax_reg + 2'd1;
                end

                lmsp_pkg::S_DMAG:
                begin
                    mag_reg[ax_reg]  <= dmag;
                    dneg_reg[ax_reg] <= diff[32];
                    if (dmag[31])
                        big_reg <= 1'b1;
                    if (ax_reg == 2'd2)
                    begin
                        ax_reg    <= 2'd0;
                        sq_n_reg  <= 64'd0;
                        state_reg <= lmsp_pkg::S_DSQ;
                    end
                    else
                        ax_reg <= ax_reg + 2'd1;
                end

                lmsp_pkg::S_DSQ:
                begin
                    sq_n_reg <= sq_n_reg + {2'b0, sq_p};
                    if (ax_reg == 2'd2)
                    begin
                        ax_reg    <= 2'd0;
                        sq_r_reg  <= 64'd0;
                        sq_b_reg  <= 64'h4000_0000_0000_0000;
                        state_reg <= lmsp_pkg::S_DSQRT;
                    end
                    else
                        ax_reg <= ax_reg + 2'd1;
                end

                lmsp_pkg::S_DSQRT:
                begin
                    // one root bit per cycle
                    if (sq_ge)
                        sq_n_reg <= sq_n_reg - sq_t;
                    sq_r_reg <= sq_r_next;
                    sq_b_reg <= sq_b_reg >> 2;
                    if (sq_b_reg[0])
                    begin
                        dist_reg  <= dist_next;
                        state_reg <= dsel_reg ? lmsp_pkg::S_TDEC : lmsp_pkg::S_GDEC;
                    end
                end

                lmsp_pkg::S_GDEC:
                begin
                    for (int i = 0; i < 3; i++)
                        moving_reg[i] <= settled_reg[i];
                    if (dist_reg < MinStepD)
                    begin
                        phase_reg      <= lmsp_pkg::PH_IDLE;
                        res_pos_reg    <= settled_reg;
                        res_status_reg <= lmsp_pkg::ST_DONE;
                        state_reg      <= lmsp_pkg::S_EMIT;
                    end
                    else
                    begin
                        total_reg   <= dist_reg;
                        remain_reg  <= dist_reg;
                        phase_reg   <= lmsp_pkg::PH_ACCEL;
                        ax_reg      <= 2'd0;
                        div_den_reg <= dist_reg;
                        div_cnt_reg <= 6'd0;
                        state_reg   <= lmsp_pkg::S_UDIV;
                    end
                end

                lmsp_pkg::S_UDIV:
                begin
                    if (div_cnt_reg == 6'd0)
                    begin
                        // load the next axis: |diff| << FRAC_BITS, left aligned
                        div_num_reg <= {mag_reg[ax_reg], 32'd0};
                        div_rem_reg <= 34'd0;
                        div_quo_reg <= 64'd0;
                        div_cnt_reg <= UdivIters;
                    end
                    else
                    begin
                        div_rem_reg <= div_rem_next;
                        div_num_reg <= div_num_reg << 1;
                        div_quo_reg <= div_quo_next;
                        div_cnt_reg <= div_cnt_reg - 6'd1;
                        if (div_cnt_reg == 6'd1)
                        begin
                            umag_reg[ax_reg] <= div_quo_next[UW-1:0];
                            uneg_reg[ax_reg] <= ~dneg_reg[ax_reg];
                            if (ax_reg == 2'd2)
                            begin
                                res_pos_reg    <= target_reg;
                                res_status_reg <= lmsp_pkg::ST_START;
                                state_reg      <= lmsp_pkg::S_EMIT;
                            end
                            else
                                ax_reg <= ax_reg + 2'd1;
                        end
                    end
                end

                lmsp_pkg::S_TPLAN:
                begin
                    if (phase_reg == lmsp_pkg::PH_IDLE)
                    begin
                        res_pos_reg    <= settled_reg;
                        res_status_reg <= lmsp_pkg::ST_IDLE;
                        state_reg      <= lmsp_pkg::S_EMIT;
                    end
                    else if (pending_reg && !ok_reg)
                    begin
                        // actuator refused the last position: drop the move
                        phase_reg      <= lmsp_pkg::PH_IDLE;
                        pending_reg    <= 1'b0;
                        moving_reg     <= settled_reg;
                        res_pos_reg    <= settled_reg;
                        res_status_reg <= lmsp_pkg::ST_FAIL;
                        state_reg      <= lmsp_pkg::S_EMIT;
                    end
                    else
                    begin
                        phase_reg <= np;
                        ax_reg    <= 2'd0;
                        if (use_map && !map_max)
                        begin
                            x_reg     <= map_x[30:0];
                            state_reg <= lmsp_pkg::S_MMUL;
                        end
                        else
                        begin
                            step_reg  <= max_reg;
                            state_reg <= lmsp_pkg::S_ADV;
                        end
                    end
                end

                lmsp_pkg::S_MMUL:
                begin
                    div_num_reg <= {prod, 2'b0};
                    div_rem_reg <= 34'd0;
                    div_quo_reg <= 64'd0;
                    div_den_reg <= {3'b0, zone_reg};
                    div_cnt_reg <= MdivIters;
                    state_reg   <= lmsp_pkg::S_MDIV;
                end

                lmsp_pkg::S_MDIV:
                begin
                    div_rem_reg <= div_rem_next;
                    div_num_reg <= div_num_reg << 1;
                    div_quo_reg <= div_quo_next;
                    div_cnt_reg <= div_cnt_reg - 6'd1;
                    if (div_cnt_reg == 6'd1)
                    begin
                        step_reg  <= mapped_step;
                        ax_reg    <= 2'd0;
                        state_reg <= lmsp_pkg::S_ADV;
                    end
                end

                lmsp_pkg::S_ADV:
                begin
                    next_reg[ax_reg] <= adv_sat;
                    if (ax_reg == 2'd2)
                    begin
                        ax_reg    <= 2'd0;
                        dsel_reg  <= 1'b1;
                        big_reg   <= 1'b0;
                        state_reg <= lmsp_pkg::S_DMAG;
                    end
                    else
                        ax_reg <= ax_reg + 2'd1;
                end

                lmsp_pkg::S_TDEC:
                begin
                    if (phase_reg == lmsp_pkg::PH_DECEL &&
                        (dist_reg >= remain_reg || dist_reg < MinStepD))
                    begin
                        // snap to the goal
                        settled_reg    <= target_reg;
                        moving_reg     <= target_reg;
                        phase_reg      <= lmsp_pkg::PH_IDLE;
                        pending_reg    <= 1'b0;
                        res_pos_reg    <= target_reg;
                        res_status_reg <= lmsp_pkg::ST_DONE;
                    end
                    else
                    begin
                        moving_reg     <= next_reg;
                        remain_reg     <= dist_reg;
                        pending_reg    <= 1'b1;
                        res_pos_reg    <= next_reg;
                        res_status_reg <= lmsp_pkg::ST_STEP;
                    end
                    state_reg <= lmsp_pkg::S_EMIT;
                end

                lmsp_pkg::S_EMIT:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_pos_reg    <= res_pos_reg;
                        out_status_reg <= res_status_reg;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= lmsp_pkg::S_IDLE;
                    end
                end

                default:
                    state_reg <= lmsp_pkg::S_IDLE;
            endcase
        end
    end

    a_idle_not_pending: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == lmsp_pkg::PH_IDLE |-> !pending_reg)
        else $error("pending verdict with no move in progress");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg != lmsp_pkg::S_IDLE)
        else $error("accepted beat did not start work");

    a_mdiv_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lmsp_pkg::S_MDIV |-> div_cnt_reg != 6'd0)
        else $error("step divide ran past its last bit");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= 3'(lmsp_pkg::ST_IDLE))
        else $error("status code out of range");

endmodule
`default_nettype wire

// ===== sim/tb_linear_move_step_profile_unit.sv =====
// ----------------------------------------------------------------------------
// tb_linear_move_step_profile_unit: self-checking bench for the move stepper
// A bit-accurate predictor tracks the unit's state. Each accepted input beat
// queues one predicted result, and each output beat is checked field by field.
// ----------------------------------------------------------------------------
module tb_linear_move_step_profile_unit;

    typedef longint vec3_t[3];
    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        lmsp_pkg::status_t  st;
    } pos_beat_t;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam longint ONE        = 65536;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic kind = 1'b0;
    logic signed [31:0] goal_x = '0;
    logic signed [31:0] goal_y = '0;
    logic signed [31:0] goal_z = '0;
    logic actuator_ok = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic [2:0] status;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // predictor state and registers
    vec3_t settled, moving, aim, unit_dir;
    longint unsigned dist_total, dist_left;
    lmsp_pkg::phase_t move_phase;
    bit awaiting_verdict;
    longint box_lo[3], box_hi[3];
    longint unsigned ramp_zone, top_step;

    pos_beat_t expected_pos[$];
    int errors = 0;
    int beats_in = 0;
    int beats_out = 0;
    int moves_done = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    linear_move_step_profile_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .goal_x(goal_x), .goal_y(goal_y), .goal_z(goal_z),
        .actuator_ok(actuator_ok),
        .out_valid(out_valid), .out_stall(out_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .status(status),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint unsigned mag64(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned span3(vec3_t a, vec3_t b);
        longint unsigned m[3];
        longint unsigned s = 0;
        longint unsigned v;
        bit big = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = mag64(a[i] - b[i]);
            if (m[i] >= (64'd1 << 31)) big = 1;
        end
        for (int i = 0; i < 3; i++)
        begin
            v = big ? (m[i] >> 1) : m[i];
            s = s + v * v;
        end
        return big ? root_floor(s) << 1 : root_floor(s);
    endfunction

    function automatic longint unsigned ramp_step(longint x);
        longint lo = lmsp_pkg::MIN_STEP_DEF;
        longint hi = longint'(top_step);
        longint st;
        if (x < 0) x = 0;
        if (longint'(x) >= longint'(ramp_zone)) return top_step;
        st = lo + (x * (hi - lo)) / longint'(ramp_zone);
        if (st > hi) st = hi;
        return longint'(st);
    endfunction

    function automatic vec3_t step_along(vec3_t from, longint unsigned st);
        vec3_t to;
        longint d;
        for (int i = 0; i < 3; i++)
        begin
            d = longint'((mag64(unit_dir[i]) * st + 64'd32768) >> 16);
            to[i] = sat32(from[i] + (unit_dir[i] < 0 ? -d : d));
        end
        return to;
    endfunction

    function automatic pos_beat_t beat_of(vec3_t p, lmsp_pkg::status_t st);
        pos_beat_t r;
        r.x = p[0][31:0];
        r.y = p[1][31:0];
        r.z = p[2][31:0];
        r.st = st;
        return r;
    endfunction

    function automatic longint clamp_axis(longint v, int a);
        if (v < box_lo[a]) v = box_lo[a];
        if (v > box_hi[a]) v = box_hi[a];
        return v;
    endfunction

    // advance the predicted state by one beat and return its result
    function automatic pos_beat_t predict_position(logic k, longint gx, longint gy,
                                                   longint gz, logic ok);
        vec3_t g, nxt;
        longint unsigned d;
        longint unsigned st = 0;
        longint df, q, full_d, prev_d;
        if (!k)
        begin
            g[0] = clamp_axis(gx, 0);
            g[1] = clamp_axis(gy, 1);
            g[2] = clamp_axis(gz, 2);
            awaiting_verdict = 0;
            d = span3(settled, g);
            if (d < lmsp_pkg::MIN_STEP_DEF)
            begin
                move_phase = lmsp_pkg::PH_IDLE;
                moving = settled;
                return beat_of(settled, lmsp_pkg::ST_DONE);
            end
            for (int i = 0; i < 3; i++)
            begin
                df = g[i] - settled[i];
                q = longint'((mag64(df) << 16) / d);
                aim[i] = g[i];
                unit_dir[i] = df < 0 ? -q : q;
            end
            moving = settled;
            dist_total = d;
            dist_left = d;
            move_phase = lmsp_pkg::PH_ACCEL;
            return beat_of(aim, lmsp_pkg::ST_START);
        end
        if (move_phase == lmsp_pkg::PH_IDLE)
            return beat_of(settled, lmsp_pkg::ST_IDLE);
        if (awaiting_verdict && !ok)
        begin
            move_phase = lmsp_pkg::PH_IDLE;
            awaiting_verdict = 0;
            moving = settled;
            return beat_of(settled, lmsp_pkg::ST_FAIL);
        end
        full_d = longint'(dist_total);
        prev_d = longint'(dist_left);
        if (move_phase == lmsp_pkg::PH_ACCEL)
        begin
            if (full_d - prev_d > longint'(ramp_zone))
                move_phase = lmsp_pkg::PH_FULL;
            else if (prev_d < longint'(ramp_zone) && prev_d * 2 < full_d)
                move_phase = lmsp_pkg::PH_DECEL;
            else
                st = ramp_step(full_d - prev_d);
        end
        if (move_phase == lmsp_pkg::PH_FULL)
        begin
            if (prev_d < longint'(ramp_zone)) move_phase = lmsp_pkg::PH_DECEL;
            else st = top_step;
        end
        if (move_phase == lmsp_pkg::PH_DECEL)
        begin
            st = ramp_step(prev_d);
            nxt = step_along(moving, st);
            d = span3(nxt, aim);
            if (d >= dist_left || d < lmsp_pkg::MIN_STEP_DEF)
            begin
                settled = aim;
                moving = aim;
                move_phase = lmsp_pkg::PH_IDLE;
                awaiting_verdict = 0;
                return beat_of(aim, lmsp_pkg::ST_DONE);
            end
        end
        else
            nxt = step_along(moving, st);
        moving = nxt;
        dist_left = span3(moving, aim);
        awaiting_verdict = 1;
        return beat_of(moving, lmsp_pkg::ST_STEP);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH beat %0d %s: got %0d expected %0d", beats_out, what, got, want);
        errors++;
    endtask

    // one input beat; the prediction is taken when the beat is accepted
    task automatic send_beat(logic k, logic signed [31:0] gx, logic signed [31:0] gy,
                             logic signed [31:0] gz, logic ok);
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        kind = k;
        goal_x = gx;
        goal_y = gy;
        goal_z = gz;
        actuator_ok = ok;
        in_valid = 1'b1;
        // stall only moves at rising edges, so a low stall here means taken next edge
        while (in_stall) @(negedge clk);
        @(posedge clk);
        expected_pos.push_back(predict_position(k, longint'(gx), longint'(gy),
                                                longint'(gz), ok));
        if (k == 1'b0 && move_phase == lmsp_pkg::PH_IDLE) moves_done++;
        beats_in++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_goal(longint gx, longint gy, longint gz);
        send_beat(1'b0, gx[31:0], gy[31:0], gz[31:0], $urandom_range(1));
    endtask

    // tick until the move ends or the cap is reached; reject_pct drives aborts
    task automatic run_move(int cap, int reject_pct);
        int n = 0;
        while (move_phase != lmsp_pkg::PH_IDLE && n < cap)
        begin
            send_beat(1'b1, $urandom, $urandom, $urandom, $urandom_range(99) >= reject_pct);
            n++;
            if (move_phase == lmsp_pkg::PH_IDLE) moves_done++;
        end
    endtask

    task automatic drain();
        wait (expected_pos.size() == 0);
        repeat (300) @(negedge clk);
    endtask

    task automatic write_reg(lmsp_pkg::cfg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        case (idx)
            lmsp_pkg::CFG_X_LOWER:    box_lo[0] = longint'(signed'(value));
            lmsp_pkg::CFG_X_UPPER:    box_hi[0] = longint'(signed'(value));
            lmsp_pkg::CFG_Y_LOWER:    box_lo[1] = longint'(signed'(value));
            lmsp_pkg::CFG_Y_UPPER:    box_hi[1] = longint'(signed'(value));
            lmsp_pkg::CFG_Z_LOWER:    box_lo[2] = longint'(signed'(value));
            lmsp_pkg::CFG_Z_UPPER:    box_hi[2] = longint'(signed'(value));
            lmsp_pkg::CFG_ACCEL_ZONE: ramp_zone = value[30:0];
            lmsp_pkg::CFG_MAX_STEP:   top_step = value[30:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_box(longint lo, longint hi);
        write_reg(lmsp_pkg::CFG_X_LOWER, lo[31:0]);
        write_reg(lmsp_pkg::CFG_X_UPPER, hi[31:0]);
        write_reg(lmsp_pkg::CFG_Y_LOWER, lo[31:0]);
        write_reg(lmsp_pkg::CFG_Y_UPPER, hi[31:0]);
        write_reg(lmsp_pkg::CFG_Z_LOWER, lo[31:0]);
        write_reg(lmsp_pkg::CFG_Z_UPPER, hi[31:0]);
    endtask

    task automatic test_defaults();
        send_goal(0, 0, 0);                       // closer than min step: done at once
        send_beat(1'b1, '0, '0, '0, 1'b1);        // tick while idle
        send_goal(2 * ONE, -ONE, ONE / 2);
        run_move(200, 0);
        send_goal(-3 * ONE, 0, 0);
        run_move(3, 0);
        send_goal(ONE, ONE, ONE);                 // goal during a move
        run_move(4, 0);
        send_beat(1'b1, '0, '0, '0, 1'b0);        // rejected position
    endtask

    task automatic test_extremes();
        drain();
        set_box(-64'sd2147483648, 64'sd2147483647);
        write_reg(lmsp_pkg::CFG_ACCEL_ZONE, 32'h7fffffff);
        write_reg(lmsp_pkg::CFG_MAX_STEP, 32'h7fffffff);
        send_goal(64'sd2147483647, -64'sd2147483648, 64'sd2147483647);
        run_move(6, 0);
        send_goal(-64'sd2147483648, 64'sd2147483647, -64'sd2147483648);
        run_move(6, 0);
        drain();
        write_reg(lmsp_pkg::CFG_ACCEL_ZONE, 32'd1);
        write_reg(lmsp_pkg::CFG_MAX_STEP, 32'd100);         // below min step
        set_box(5 * ONE, -5 * ONE);               // crossed bounds
        send_goal(0, 9 * ONE, -9 * ONE);
        run_move(4, 0);
        drain();
        set_box(-ONE, ONE);
        write_reg(lmsp_pkg::CFG_MAX_STEP, 32'd8000);
        send_goal(ONE, -ONE, ONE);
        run_move(60, 0);
    endtask

    task automatic test_random(int n_beats, int s_pct, int r_pct);
        int start = beats_in;
        longint lo, hi;
        drain();
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        lo = -longint'($urandom_range(20 * ONE, 1));
        hi = longint'($urandom_range(20 * ONE, 1));
        if ($urandom_range(5) == 0) set_box(hi, lo);
        else set_box(lo, hi);
        write_reg(lmsp_pkg::CFG_ACCEL_ZONE, $urandom_range(6 * ONE, 1));
        write_reg(lmsp_pkg::CFG_MAX_STEP, $urandom_range(3 * ONE, 6000));
        while (beats_in - start < n_beats)
        begin
            case ($urandom_range(9))
                0: send_beat($urandom_range(1), $urandom, $urandom, $urandom,
                             $urandom_range(1));
                1:
                begin
                    hold_left = HOLD_CYCLES;
                    send_goal($signed($urandom_range(40 * ONE)) - 20 * ONE, 0, ONE);
                    run_move(6, 0);
                end
                2:
                begin
                    wait (expected_pos.size() == 0);
                    send_goal(settled[0] + $urandom_range(600), settled[1], settled[2]);
                end
                default:
                begin
                    send_goal($signed($urandom_range(50 * ONE)) - 25 * ONE,
                              $signed($urandom_range(50 * ONE)) - 25 * ONE,
                              $signed($urandom_range(50 * ONE)) - 25 * ONE);
                    run_move($urandom_range(60, 3), $urandom_range(4));
                end
            endcase
        end
    endtask

    // receiver side: random stall plus long hold-offs
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct;
    end

    always @(posedge clk)
    begin
        pos_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_out++;
            if (expected_pos.size() == 0)
                report_mismatch("result with nothing expected, status", status, -1);
            else
            begin
                want = expected_pos.pop_front();
                if (pos_x !== want.x) report_mismatch("pos_x", pos_x, want.x);
                if (pos_y !== want.y) report_mismatch("pos_y", pos_y, want.y);
                if (pos_z !== want.z) report_mismatch("pos_z", pos_z, want.z);
                if (status !== want.st) report_mismatch("status", status, want.st);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        settled = '{0, 0, longint'(lmsp_pkg::HOME_Z_DEF)};
        moving = settled;
        aim = '{0, 0, 0};
        unit_dir = '{0, 0, 0};
        dist_total = 0;
        dist_left = 0;
        move_phase = lmsp_pkg::PH_IDLE;
        awaiting_verdict = 0;
        for (int i = 0; i < 3; i++)
        begin
            box_lo[i] = longint'(lmsp_pkg::BOX_LO_RST);
            box_hi[i] = longint'(lmsp_pkg::BOX_HI_RST);
        end
        ramp_zone = lmsp_pkg::ZONE_RST;
        top_step = lmsp_pkg::MAX_STEP_RST;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_defaults();
        test_extremes();
        test_random(290, 38, 58);
        test_random(290, 58, 38);
        test_random(290, 0, 0);
        wait (expected_pos.size() == 0);
        repeat (300) @(posedge clk);
        $display("Covered %0d input beats, %0d results, %0d finished or dropped moves",
                 beats_in, beats_out, moves_done);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/lmsp_pkg.sv
hdl/linear_move_step_profile_unit.sv
sim/tb_linear_move_step_profile_unit.sv
